>>> hdl/pmrs8_pkg.sv
package pmrs8_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int RECIP_BITS    = 16;
    localparam int INPUT_WORDS   = 4;
    localparam int MAX_CHANNELS  = 4;
    localparam int MAX_CH_EFF    = (MAX_CHANNELS < INPUT_WORDS) ? MAX_CHANNELS : INPUT_WORDS;

    localparam int WORD_W  = 32;
    localparam int RATIO_W = 24;
    localparam int RECIP_W = 16;
    localparam int CFG_W   = 24;
    // channel sum of up to four signed bytes
    localparam int SUM_W   = 10;
    // window remainder never exceeds the ratio
    localparam int COV_W   = RATIO_W;
    localparam int TAKE_W  = FRACTION_BITS + 1;
    localparam int PHASE_W = FRACTION_BITS + 1;
    // |window sum| < 2^9 * 2^24
    localparam int WSUM_W  = 35;
    localparam int MAG_W   = WSUM_W - 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int Q_W     = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRACTION_BITS;
    localparam logic [TAKE_W-1:0]  TAKE_ONE  = TAKE_W'(1) << FRACTION_BITS;
    localparam logic [7:0]         UNSIGNED_BIAS = 8'h80;

    typedef enum logic [1:0]
    {
        CFG_SAMPLE_BYTES,
        CFG_CHANNEL_COUNT,
        CFG_STEP_RATIO,
        CFG_STEP_RECIPROCAL
    } cfg_index_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_MUL,
        BK_ROUND,
        BK_EMIT
    } back_state_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] chan0_word;
        logic [WORD_W-1:0] chan1_word;
        logic [WORD_W-1:0] chan2_word;
        logic [WORD_W-1:0] chan3_word;
    } frame_t;

    typedef struct packed
    {
        logic signed [7:0] out_sample;
        logic              run_last;
    } result_t;

    typedef struct packed
    {
        logic [2:0]         sample_bytes;
        logic [2:0]         channel_count;
        logic [RATIO_W-1:0] step_ratio;
        logic [RECIP_W-1:0] step_reciprocal;
    } cfg_t;

    typedef struct packed
    {
        logic signed [SUM_W-1:0] sum;
        logic                    down;
    } entry_t;

    typedef struct packed
    {
        logic   valid;
        entry_t entry;
    } head_t;

    function automatic logic [2:0] effective_count(logic [2:0] cc);
        logic [2:0] n;
        n = cc;
        if (n == 3'd0)
        begin
            n = 3'd1;
        end
        if (n > 3'(MAX_CH_EFF))
        begin
            n = 3'(MAX_CH_EFF);
        end
        return n;
    endfunction

    function automatic logic ratio_is_down(logic [RATIO_W-1:0] ratio);
        return ratio > RATIO_ONE;
    endfunction

    // floor(y / n) for n of one to four; the factor for three is exact below 2048
    function automatic logic [Q_W-1:0] div_count(logic [Q_W-1:0] y, logic [2:0] n);
        logic [Q_W+9:0] scaled;
        logic [Q_W-1:0] q;
        scaled = (Q_W + 10)'(y) * (Q_W + 10)'(683);
        case (n)
            3'd2:    q = y >> 1;
            3'd3:    q = Q_W'(scaled[Q_W+9:11]);
            3'd4:    q = y >> 2;
            default: q = y;
        endcase
        return q;
    endfunction

    function automatic logic signed [7:0] round_sat(logic neg, logic [Q_W-1:0] q);
        logic [7:0] v;
        if (neg)
        begin
            v = (q > Q_W'(128)) ? 8'h80 : (8'd0 - q[7:0]);
        end
        else
        begin
            v = (q > Q_W'(127)) ? 8'h7F : q[7:0];
        end
        return $signed(v);
    endfunction

endpackage

>>> hdl/pmrs8_front.sv
module pmrs8_front
(
    input  pmrs8_pkg::frame_t frame,
    input  logic              frame_valid,
    input  pmrs8_pkg::cfg_t   cfg,
    input  logic              queue_full,
    output logic              push,
    output pmrs8_pkg::entry_t push_entry
);

    function automatic logic signed [7:0] top_byte(logic [pmrs8_pkg::WORD_W-1:0] word,
                                                   logic [2:0] bytes);
        logic [7:0] b;
        case (bytes)
            3'd0, 3'd1: b = word[7:0] ^ pmrs8_pkg::UNSIGNED_BIAS;
            3'd2:       b = word[15:8];
            3'd3:       b = word[23:16];
            default:    b = word[31:24];
        endcase
        return $signed(b);
    endfunction

    logic [pmrs8_pkg::WORD_W-1:0] words [pmrs8_pkg::INPUT_WORDS];
    logic [2:0]                   n_eff;

    assign words[0] = frame.chan0_word;
    assign words[1] = frame.chan1_word;
    assign words[2] = frame.chan2_word;
    assign words[3] = frame.chan3_word;
    assign n_eff    = pmrs8_pkg::effective_count(cfg.channel_count);

    // sum the active lanes; the division by the count waits for rounding
    always_comb
    begin
        logic signed [pmrs8_pkg::SUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < pmrs8_pkg::INPUT_WORDS; i++)
        begin
            if (3'(i) < n_eff)
            begin
                acc = acc + pmrs8_pkg::SUM_W'(top_byte(words[i], cfg.sample_bytes));
            end
        end
        push_entry.sum  = acc;
        push_entry.down = pmrs8_pkg::ratio_is_down(cfg.step_ratio);
    end

    assign push = frame_valid && !queue_full;

endmodule

>>> hdl/pmrs8_queue.sv
module pmrs8_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pmrs8_pkg::entry_t push_entry,
    input  logic              pop,
    output logic              full,
    output pmrs8_pkg::head_t  head
);

    localparam int PTR_W = $clog2(pmrs8_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pmrs8_pkg::QUEUE_DEPTH + 1);

    pmrs8_pkg::entry_t entry_reg [pmrs8_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign full       = count_reg == CNT_W'(pmrs8_pkg::QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(pmrs8_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(pmrs8_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hdl/pmrs8_back.sv
module pmrs8_back
#(
    parameter int MAX_REPEAT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pmrs8_pkg::cfg_t    cfg,
    input  pmrs8_pkg::head_t   head,
    output logic               pop,
    output logic               sample_valid,
    input  logic               sample_stall,
    output pmrs8_pkg::result_t sample
);

    localparam int CNT_W = (MAX_REPEAT > 2) ? $clog2(MAX_REPEAT) : 1;
    localparam int TP_W  = pmrs8_pkg::SUM_W + pmrs8_pkg::TAKE_W + 1;

    pmrs8_pkg::back_state_t state_reg, state_next;

    logic signed [pmrs8_pkg::WSUM_W-1:0] ws_reg, ws_next;
    logic signed [pmrs8_pkg::WSUM_W-1:0] close_reg, close_next;
    logic [pmrs8_pkg::COV_W-1:0]         cov_reg, cov_next;
    logic [pmrs8_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [pmrs8_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic                                neg_reg, neg_next;
    logic signed [7:0]                   level_reg, level_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    pmrs8_pkg::result_t                  out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    logic [2:0] n_eff;
    logic       slot_free;

    assign n_eff        = pmrs8_pkg::effective_count(cfg.channel_count);
    assign slot_free    = !out_valid_reg || !sample_stall;
    assign sample_valid = out_valid_reg;
    assign sample       = out_reg;

    always_comb
    begin
        logic [pmrs8_pkg::COV_W-1:0]         cov_eff;
        logic [pmrs8_pkg::TAKE_W-1:0]        take;
        logic [pmrs8_pkg::TAKE_W-1:0]        rest;
        logic                                closes;
        logic signed [TP_W-1:0]              tp;
        logic signed [pmrs8_pkg::WSUM_W-1:0] tp_ext;
        logic signed [pmrs8_pkg::WSUM_W-1:0] sum_one;
        logic signed [pmrs8_pkg::WSUM_W-1:0] ws_final;
        logic [pmrs8_pkg::SUM_W-1:0]         sum_mag;
        logic [pmrs8_pkg::Q_W:0]             rnum;
        logic [pmrs8_pkg::WSUM_W-1:0]        close_abs;
        logic [pmrs8_pkg::PROD_W:0]          rsum;
        logic [pmrs8_pkg::Q_W-1:0]           y;
        logic [pmrs8_pkg::PHASE_W-1:0]       phase_sum;
        logic                                last;

        state_next     = state_reg;
        ws_next        = ws_reg;
        close_next     = close_reg;
        cov_next       = cov_reg;
        phase_next     = phase_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        level_next     = level_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && sample_stall;
        pop            = 1'b0;

        // box filter step: at most one window closes per frame
        cov_eff  = (cov_reg == '0) ? cfg.step_ratio : cov_reg;
        closes   = cov_eff <= pmrs8_pkg::RATIO_ONE;
        take     = closes ? cov_eff[pmrs8_pkg::TAKE_W-1:0] : pmrs8_pkg::TAKE_ONE;
        rest     = pmrs8_pkg::TAKE_ONE - take;
        tp       = head.entry.sum * $signed({1'b0, take});
        tp_ext   = {{(pmrs8_pkg::WSUM_W - TP_W){tp[TP_W-1]}}, tp};
        sum_one  = {{(pmrs8_pkg::WSUM_W - pmrs8_pkg::SUM_W - pmrs8_pkg::FRACTION_BITS)
                     {head.entry.sum[pmrs8_pkg::SUM_W-1]}},
                    head.entry.sum, pmrs8_pkg::FRACTION_BITS'(0)};
        ws_final = ws_reg + tp_ext;

        // repeat level: round(sum / n), ties away from zero
        sum_mag = head.entry.sum[pmrs8_pkg::SUM_W-1] ? (~head.entry.sum + 1'b1)
                                                     : head.entry.sum;
        rnum    = {sum_mag, 1'b0} + (pmrs8_pkg::Q_W + 1)'(n_eff);

        close_abs = close_reg[pmrs8_pkg::WSUM_W-1] ? (~close_reg + 1'b1) : close_reg;
        rsum      = (pmrs8_pkg::PROD_W + 1)'(prod_reg)
                  + ((pmrs8_pkg::PROD_W + 1)'(n_eff)
                     << (pmrs8_pkg::FRACTION_BITS + pmrs8_pkg::RECIP_BITS - 1));
        // anything at or above 1024 saturates for every count
        y = (|rsum[pmrs8_pkg::PROD_W:pmrs8_pkg::FRACTION_BITS + pmrs8_pkg::RECIP_BITS
                   + pmrs8_pkg::Q_W])
            ? '1
            : rsum[pmrs8_pkg::FRACTION_BITS + pmrs8_pkg::RECIP_BITS +: pmrs8_pkg::Q_W];

        phase_sum = phase_reg + cfg.step_ratio[pmrs8_pkg::PHASE_W-1:0];
        last      = (phase_sum >= pmrs8_pkg::PHASE_W'(pmrs8_pkg::TAKE_ONE))
                 || (cnt_reg == CNT_W'(MAX_REPEAT - 1));

        case (state_reg)
            pmrs8_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.entry.down)
                    begin
                        if (closes)
                        begin
                            close_next = ws_final;
                            ws_next    = sum_one - tp_ext;
                            cov_next   = (rest == '0) ? '0
                                       : cfg.step_ratio - pmrs8_pkg::COV_W'(rest);
                            state_next = pmrs8_pkg::BK_MUL;
                        end
                        else
                        begin
                            ws_next  = ws_final;
                            cov_next = cov_eff - pmrs8_pkg::RATIO_ONE;
                        end
                    end
                    else
                    begin
                        level_next = pmrs8_pkg::round_sat(head.entry.sum[pmrs8_pkg::SUM_W-1],
                            pmrs8_pkg::div_count(rnum[pmrs8_pkg::Q_W:1], n_eff));
                        cnt_next   = '0;
                        state_next = pmrs8_pkg::BK_EMIT;
                    end
                end
            end
            pmrs8_pkg::BK_MUL:
            begin
                neg_next   = close_reg[pmrs8_pkg::WSUM_W-1];
                prod_next  = close_abs[pmrs8_pkg::MAG_W-1:0] * cfg.step_reciprocal;
                state_next = pmrs8_pkg::BK_ROUND;
            end
            pmrs8_pkg::BK_ROUND:
            begin
                if (slot_free)
                begin
                    out_next.out_sample = pmrs8_pkg::round_sat(neg_reg,
                                                               pmrs8_pkg::div_count(y, n_eff));
                    out_next.run_last   = 1'b1;
                    out_valid_next      = 1'b1;
                    state_next          = pmrs8_pkg::BK_IDLE;
                end
            end
            pmrs8_pkg::BK_EMIT:
            begin
                if (slot_free)
                begin
                    out_next.out_sample = level_reg;
                    out_next.run_last   = last;
                    out_valid_next      = 1'b1;
                    if (last)
                    begin
                        phase_next = (phase_sum >= pmrs8_pkg::PHASE_W'(pmrs8_pkg::TAKE_ONE))
                                   ? phase_sum - pmrs8_pkg::PHASE_W'(pmrs8_pkg::TAKE_ONE)
                                   : '0;
                        state_next = pmrs8_pkg::BK_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_sum;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = pmrs8_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pmrs8_pkg::BK_IDLE;
            ws_reg        <= '0;
            cov_reg       <= '0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            cov_reg       <= cov_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        close_reg <= close_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        level_reg <= level_next;
        out_reg   <= out_next;
    end

endmodule

>>> hdl/pcm_mix_and_resample_to_s8_unit.sv
// PCM mixer and rate converter to signed 8-bit mono. Each request carries up
// to four raw channel words; the top sample byte of each active channel is
// taken (8-bit samples lose their 0x80 offset), summed, and either folded
// into a box-filter window (ratio above one, one result per window, scaled
// by the reciprocal register) or repeated for each output phase that falls
// on the frame (ratio of one or less, up to MAX_REPEAT results, the last one
// flagged with run_last). A frame request is taken in any cycle the two-entry
// queue has room. The back end's single sequencer accumulates a frame that
// leaves its window open, takes a frame that closes one through accumulate,
// multiply by the reciprocal and round, and follows a repeated frame with an
// emit step for each result, so a downsampling stream runs at one frame per
// cycle while windows stay open. Results sit in an output register, so work
// continues while a result waits to be taken. No clearing pass follows
// reset. Write configuration only while the block is idle; a window left
// open keeps its coverage across register changes.
module pcm_mix_and_resample_to_s8_unit
#(
    parameter int MAX_REPEAT = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [pmrs8_pkg::CFG_W-1:0]     cfg_data,

    input  logic                            frame_valid,
    output logic                            frame_stall,
    input  pmrs8_pkg::frame_t               frame,

    output logic                            sample_valid,
    input  logic                            sample_stall,
    output pmrs8_pkg::result_t              sample
);

    pmrs8_pkg::cfg_t   cfg_reg, cfg_next;
    pmrs8_pkg::entry_t push_entry;
    pmrs8_pkg::head_t  q_head;
    logic              push;
    logic              pop;
    logic              q_full;

    // configuration: decode the index and hold each register until rewritten
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                pmrs8_pkg::CFG_SAMPLE_BYTES:    cfg_next.sample_bytes    = cfg_data[2:0];
                pmrs8_pkg::CFG_CHANNEL_COUNT:   cfg_next.channel_count   = cfg_data[2:0];
                pmrs8_pkg::CFG_STEP_RATIO:
                    cfg_next.step_ratio = cfg_data[pmrs8_pkg::RATIO_W-1:0];
                pmrs8_pkg::CFG_STEP_RECIPROCAL:
                    cfg_next.step_reciprocal = cfg_data[pmrs8_pkg::RECIP_W-1:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_bytes    <= 3'd2;
            cfg_reg.channel_count   <= 3'd1;
            cfg_reg.step_ratio      <= pmrs8_pkg::RATIO_ONE;
            cfg_reg.step_reciprocal <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: take the frame request, mix the channels, classify the mode
    pmrs8_front u_front
    (
        .frame       (frame),
        .frame_valid (frame_valid),
        .cfg         (cfg_reg),
        .queue_full  (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // hold mixed frames between the two halves so each can stall on its own
    pmrs8_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head       (q_head)
    );

    // back: advance the window or the repeat phase and emit results
    pmrs8_back
    #(
        .MAX_REPEAT (MAX_REPEAT)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (q_head),
        .pop          (pop),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample)
    );

    assign frame_stall = q_full;

    // a downsampled window yields exactly one result, so that result is last
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && pmrs8_pkg::ratio_is_down(cfg_reg.step_ratio) |-> sample.run_last)
        else $error("downsampled result without run_last");

    // a stalled frame request means the queue holds work for the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> q_head.valid)
        else $error("frame stalled while the queue is empty");

    // a frame request taken with the queue empty is at the head next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_head.valid |=> q_head.valid)
        else $error("accepted frame lost in the queue");

endmodule

>>> tb/sv/pmrs8_sample_checker.sv
module pmrs8_sample_checker
#(
    parameter int MAX_REPEAT = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [pmrs8_pkg::CFG_W-1:0] cfg_data,

    input  logic                        frame_valid,
    input  logic                        frame_stall,
    input  pmrs8_pkg::frame_t           frame,

    input  logic                        sample_valid,
    input  logic                        sample_stall,
    input  pmrs8_pkg::result_t          sample,

    output int                          fail_count,
    output int                          pending,
    output int                          samples_checked
);

    localparam longint ONE = longint'(1) << pmrs8_pkg::FRACTION_BITS;

    // register copies
    logic [2:0]                    bytes_reg;
    logic [2:0]                    count_reg;
    logic [pmrs8_pkg::RATIO_W-1:0] ratio_reg;
    logic [pmrs8_pkg::RECIP_W-1:0] recip_reg;

    // filter state
    longint window_left;
    longint window_acc;
    longint phase;

    pmrs8_pkg::result_t expected_samples[$];
    int                 fails;
    int                 checked;

    function automatic int top_byte(logic [31:0] w, int unsigned nb);
        logic [7:0] b;
        b = 8'(w >> (8 * (nb - 1)));
        if (nb == 1)
        begin
            return int'(b) - int'(pmrs8_pkg::UNSIGNED_BIAS);
        end
        return int'($signed(b));
    endfunction

    // ties away from zero; den is positive
    function automatic longint round_half_away(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [7:0] clip8(longint v);
        if (v > 127)
        begin
            v = 127;
        end
        if (v < -128)
        begin
            v = -128;
        end
        return 8'(v);
    endfunction

    task automatic resample_frame(pmrs8_pkg::frame_t f);
        logic [31:0]        words[pmrs8_pkg::INPUT_WORDS];
        logic signed [7:0]  vals[$];
        logic signed [7:0]  v;
        int unsigned        nb;
        int unsigned        nc;
        longint             csum;
        longint             ratio;
        longint             w;
        longint             take;
        longint             den;
        pmrs8_pkg::result_t r;
        words[0] = f.chan0_word;
        words[1] = f.chan1_word;
        words[2] = f.chan2_word;
        words[3] = f.chan3_word;
        nb = bytes_reg;
        nc = count_reg;
        if (nb == 0)
        begin
            nb = 1;
        end
        if (nb > 4)
        begin
            nb = 4;
        end
        if (nc == 0)
        begin
            nc = 1;
        end
        if (nc > pmrs8_pkg::MAX_CH_EFF)
        begin
            nc = pmrs8_pkg::MAX_CH_EFF;
        end
        csum = 0;
        for (int i = 0; i < nc; i++)
        begin
            csum += top_byte(words[i], nb);
        end
        ratio = longint'(ratio_reg);
        if (ratio > ONE)
        begin
            w = ONE;
            while (w > 0)
            begin
                if (window_left == 0)
                begin
                    window_left = ratio;
                end
                take = (w < window_left) ? w : window_left;
                window_acc += csum * take;
                window_left -= take;
                w -= take;
                if (window_left == 0)
                begin
                    den = longint'(nc) << (pmrs8_pkg::FRACTION_BITS + pmrs8_pkg::RECIP_BITS);
                    vals.push_back(clip8(round_half_away(window_acc * longint'(recip_reg), den)));
                    window_acc = 0;
                end
            end
        end
        else
        begin
            v = clip8(round_half_away(csum, longint'(nc)));
            while (phase < ONE && vals.size() < MAX_REPEAT)
            begin
                vals.push_back(v);
                phase += ratio;
            end
            // drop whatever phases the cap left inside this frame
            phase = (phase < ONE) ? 0 : phase - ONE;
        end
        foreach (vals[i])
        begin
            r.out_sample = vals[i];
            r.run_last   = (i == vals.size() - 1);
            expected_samples.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg   = 3'd2;
            count_reg   = 3'd1;
            ratio_reg   = pmrs8_pkg::RATIO_ONE;
            recip_reg   = 16'hFFFF;
            window_left = 0;
            window_acc  = 0;
            phase       = 0;
            fails       = 0;
            checked     = 0;
            expected_samples.delete();
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("out_sample: expected none, got %0d", sample.out_sample);
                    fails++;
                end
                else
                begin
                    pmrs8_pkg::result_t e;
                    e = expected_samples.pop_front();
                    if (sample.out_sample !== e.out_sample)
                    begin
                        $error("out_sample: expected %0d, got %0d",
                               e.out_sample, sample.out_sample);
                        fails++;
                    end
                    if (sample.run_last !== e.run_last)
                    begin
                        $error("run_last: expected %0d, got %0d", e.run_last, sample.run_last);
                        fails++;
                    end
                    checked++;
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    pmrs8_pkg::CFG_SAMPLE_BYTES:    bytes_reg = cfg_data[2:0];
                    pmrs8_pkg::CFG_CHANNEL_COUNT:   count_reg = cfg_data[2:0];
                    pmrs8_pkg::CFG_STEP_RATIO:
                        ratio_reg = cfg_data[pmrs8_pkg::RATIO_W-1:0];
                    pmrs8_pkg::CFG_STEP_RECIPROCAL:
                        recip_reg = cfg_data[pmrs8_pkg::RECIP_W-1:0];
                    default: ;
                endcase
            end
            if (frame_valid && !frame_stall)
            begin
                resample_frame(frame);
            end
        end
        fail_count      <= fails;
        pending         <= expected_samples.size();
        samples_checked <= checked;
    end

endmodule

>>> tb/sv/tb_pcm_mix_and_resample_to_s8_unit.sv
module tb_pcm_mix_and_resample_to_s8_unit;

    localparam int REPEAT_CAP    = 64;
    // cycles of quiet after the last result: room for two queued requests plus
    // the close of a window, with margin
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 22;
    localparam int RANDOM_FRAMES = 100;
    localparam int LONG_FRAMES   = 30;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_write    = 1'b0;
    pmrs8_pkg::cfg_index_t       cfg_index    = pmrs8_pkg::CFG_SAMPLE_BYTES;
    logic [pmrs8_pkg::CFG_W-1:0] cfg_data     = '0;
    logic                        frame_valid  = 1'b0;
    logic                        frame_stall;
    pmrs8_pkg::frame_t           frame        = '0;
    logic                        sample_valid;
    logic                        sample_stall = 1'b0;
    pmrs8_pkg::result_t          sample;

    int fail_count;
    int pending;
    int samples_checked;

    // stimulus controls: calm switches idling off on both sides, a new
    // hold_ticket asks the receiver for one long hold-off
    bit calm        = 1'b0;
    int hold_ticket = 0;
    int frames_sent = 0;
    int settings    = 1;

    pcm_mix_and_resample_to_s8_unit
    #(
        .MAX_REPEAT(REPEAT_CAP)
    )
    dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample      (sample)
    );

    pmrs8_sample_checker
    #(
        .MAX_REPEAT(REPEAT_CAP)
    )
    sample_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame          (frame),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .fail_count     (fail_count),
        .pending        (pending),
        .samples_checked(samples_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: stall at random, hold off for a long stretch on request, and
    // never stall while the calm stretch runs.
    initial
    begin : receiver
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != hold_served)
            begin
                hold_served = hold_ticket;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                sample_stall <= 1'b1;
            end
            else if (calm)
            begin
                sample_stall <= 1'b0;
            end
            else
            begin
                sample_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Offer one frame request and hold it until the block takes it. Idle
    // cycles go in front of the request so they land on every stage of the
    // back end.
    task automatic offer_frame(input pmrs8_pkg::frame_t f);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame       <= f;
        @(posedge clk);
        while (frame_stall)
        begin
            @(posedge clk);
        end
        frames_sent++;
    endtask

    // Drop valid and wait until every predicted sample has been taken.
    task automatic drain_samples();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Drain, then give a frame that closes no window time to leave the back
    // end before registers change.
    task automatic settle();
        drain_samples();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leave the register write strobe high between back-to-back writes;
    // apply_setting lowers it once at the end.
    task automatic write_reg(input pmrs8_pkg::cfg_index_t idx,
                             input logic [pmrs8_pkg::CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Fill the unused upper bits of a narrow register now and then.
    function automatic logic [pmrs8_pkg::CFG_W-1:0] with_junk(logic [pmrs8_pkg::CFG_W-1:0] v,
                                                              int w);
        logic [pmrs8_pkg::CFG_W-1:0] junk;
        junk = ($urandom_range(3) == 0) ? pmrs8_pkg::CFG_W'($urandom) : '0;
        return (junk << w) | v;
    endfunction

    task automatic apply_setting(input logic [2:0] nb, input logic [2:0] nc,
                                 input logic [pmrs8_pkg::RATIO_W-1:0] ratio,
                                 input logic [pmrs8_pkg::RECIP_W-1:0] recip);
        write_reg(pmrs8_pkg::CFG_SAMPLE_BYTES, with_junk(pmrs8_pkg::CFG_W'(nb), 3));
        write_reg(pmrs8_pkg::CFG_CHANNEL_COUNT, with_junk(pmrs8_pkg::CFG_W'(nc), 3));
        write_reg(pmrs8_pkg::CFG_STEP_RATIO, pmrs8_pkg::CFG_W'(ratio));
        write_reg(pmrs8_pkg::CFG_STEP_RECIPROCAL,
                  with_junk(pmrs8_pkg::CFG_W'(recip), pmrs8_pkg::RECIP_W));
        cfg_write <= 1'b0;
        settings++;
    endtask

    // Mostly random words; now and then every byte at a signed or unsigned
    // extreme so that saturation and the 0x80 offset get hit at any size.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8080_8080;
            3:       return 32'h7F7F_7F7F;
            default: return $urandom;
        endcase
    endfunction

    function automatic pmrs8_pkg::frame_t pick_frame();
        return pmrs8_pkg::frame_t'{pick_word(), pick_word(), pick_word(), pick_word()};
    endfunction

    initial
    begin
        logic [2:0]                    nb;
        logic [2:0]                    nc;
        logic [pmrs8_pkg::RATIO_W-1:0] ratio;
        logic [pmrs8_pkg::RECIP_W-1:0] recip;
        longint                        recip_exact;
        int unsigned                   phase_no;
        int unsigned                   count;
        int unsigned                   pick;
        int unsigned                   pause_at;
        int                            random_frames;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---

        // Reset settings: 16-bit mono at ratio one, one sample per request.
        offer_frame(pmrs8_pkg::frame_t'{32'h0000_0000, $urandom, $urandom, $urandom});
        offer_frame(pmrs8_pkg::frame_t'{32'hFFFF_FFFF, $urandom, $urandom, $urandom});
        offer_frame(pmrs8_pkg::frame_t'{32'h1234_7F00, $urandom, $urandom, $urandom});
        offer_frame(pmrs8_pkg::frame_t'{32'hFFFF_80FF, $urandom, $urandom, $urandom});
        settle();

        // Unsigned 8-bit, four channels: full scale both ways and a mix.
        apply_setting(3'd1, 3'd4, pmrs8_pkg::RATIO_ONE, 16'hFFFF);
        offer_frame(pmrs8_pkg::frame_t'{32'hA5A5_A5FF, 32'h0000_00FF, 32'hFFFF_FFFF,
                                        32'h1234_56FF});
        offer_frame(pmrs8_pkg::frame_t'{32'hFFFF_FF00, 32'h0000_0000, 32'h5A5A_5A00,
                                        32'hFFFF_0000});
        offer_frame(pmrs8_pkg::frame_t'{32'h0000_0080, 32'hFFFF_FF7F, 32'h0000_0081,
                                        32'hFFFF_FF00});
        settle();

        // Size zero and count zero fall back to one; ratio one half doubles.
        apply_setting(3'd0, 3'd0, pmrs8_pkg::RATIO_W'(32'h8000), 16'h0000);
        offer_frame(pick_frame());
        offer_frame(pick_frame());
        settle();

        // Size and count above range clamp to four; tiny ratio hits the
        // repeat cap with phases still inside the frame.
        apply_setting(3'd7, 3'd7, pmrs8_pkg::RATIO_W'(1000), 16'h0000);
        offer_frame(pick_frame());
        offer_frame(pick_frame());
        settle();

        // Ratio zero: the cap alone ends the run.
        apply_setting(3'd3, 3'd3, '0, 16'h1234);
        offer_frame(pmrs8_pkg::frame_t'{32'h0080_0000, 32'h007F_FFFF, 32'hFF80_0000, $urandom});
        settle();

        // Box filter at 1.5, leaving a window open at the end.
        apply_setting(3'd4, 3'd2, pmrs8_pkg::RATIO_W'(32'h18000), 16'hAAAB);
        offer_frame(pmrs8_pkg::frame_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom, $urandom});
        offer_frame(pmrs8_pkg::frame_t'{32'h8000_0000, 32'h8000_0000, $urandom, $urandom});
        offer_frame(pick_frame());
        offer_frame(pick_frame());
        offer_frame(pick_frame());
        settle();

        // Switch to repeat mode mid-window, then back: the window resumes,
        // now scaled by a reciprocal that forces saturation.
        apply_setting(3'd4, 3'd2, pmrs8_pkg::RATIO_ONE, 16'hAAAB);
        offer_frame(pick_frame());
        offer_frame(pick_frame());
        settle();
        apply_setting(3'd4, 3'd2, pmrs8_pkg::RATIO_W'(32'h18000), 16'hFFFF);
        offer_frame(pmrs8_pkg::frame_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom, $urandom});
        offer_frame(pmrs8_pkg::frame_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom, $urandom});
        settle();

        // --- random part ---
        random_frames = 0;
        phase_no      = 0;
        while (random_frames < RANDOM_FRAMES)
        begin
            phase_no++;
            nb   = 3'($urandom_range(7));
            nc   = 3'($urandom_range(7));
            pick = $urandom_range(99);
            if (phase_no == 1)
            begin
                // just above one: nearly a sample per request, ideal to back up
                ratio = pmrs8_pkg::RATIO_W'(32'h10001);
            end
            else if (pick < 45)
            begin
                ratio = pmrs8_pkg::RATIO_W'($urandom_range(32'h10001, 32'h60000));
            end
            else if (pick < 55)
            begin
                ratio = pmrs8_pkg::RATIO_W'($urandom_range(32'h60000, 32'hFFFFF));
            end
            else if (pick < 90)
            begin
                ratio = pmrs8_pkg::RATIO_W'($urandom_range(32'h4000, 32'h10000));
            end
            else
            begin
                ratio = pmrs8_pkg::RATIO_W'($urandom_range(32'h3FFF));
            end
            recip_exact = (longint'(1) << 32) / longint'((ratio == 0) ? 1 : ratio);
            if (recip_exact > 65535)
            begin
                recip_exact = 65535;
            end
            recip = ($urandom_range(3) == 0) ? pmrs8_pkg::RECIP_W'($urandom)
                                             : pmrs8_pkg::RECIP_W'(recip_exact);
            count = (ratio < pmrs8_pkg::RATIO_W'(32'h4000)) ? $urandom_range(2, 5)
                                                            : $urandom_range(10, 25);
            // the hold-off stretch keeps offering until the queue backs up
            if (phase_no == 1)
            begin
                pause_at = count - 1;
            end
            else
            begin
                pause_at = ($urandom_range(2) == 0) ? $urandom_range(1, count - 1) : count;
            end

            apply_setting(nb, nc, ratio, recip);
            calm <= (phase_no == 2);
            if (phase_no == 1)
            begin
                // hold the receiver off while requests keep coming
                hold_ticket <= hold_ticket + 1;
            end
            for (int i = 0; i < count; i++)
            begin
                if (i == pause_at)
                begin
                    drain_samples();
                end
                offer_frame(pick_frame());
                random_frames++;
            end
            settle();
        end
        calm <= 1'b0;

        // Largest ratio: a window spans just under 256 requests.
        apply_setting(3'd2, 3'd4, pmrs8_pkg::RATIO_W'(32'hFF_FFFF), pmrs8_pkg::RECIP_W'(256));
        for (int i = 0; i < LONG_FRAMES; i++)
        begin
            offer_frame(pick_frame());
        end
        settle();

        $display("Covered %0d frame requests and %0d checked samples over %0d register settings,",
                 frames_sent, samples_checked, settings);
        $display("both filter modes, size and count clamping, repeat cap and saturation.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
